// ----- src/axis_angle_rotation_matrix_top_macros.svh -----
// assertion macros for the axis-angle rotation matrix block
// used by the top level only, no other dependencies
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_MACROS_SVH

// same-cycle implication
`define AAR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/aar_pkg.sv -----
// shared types, widths and tables for the axis-angle rotation matrix block
// no dependencies
`timescale 1ns / 1ps

package aar_pkg;

    // fixed field widths
    localparam int VAL_W   = 32;
    localparam int ANGLE_W = 16;
    localparam int ANG_EXT = 24;
    localparam int IN_W    = 6 * VAL_W + ANGLE_W;
    localparam int OUT_W   = 4 * VAL_W;
    localparam int USER_W  = 3;

    // internal widths sized for the widest fraction setting
    localparam int FRAC_MAX = 24;
    localparam int CS_W     = FRAC_MAX + 3;
    localparam int PROD_W   = 2 * CS_W;
    localparam int XW       = 34;
    localparam int ZW       = 33;
    localparam int RW       = 66;
    localparam int ROOT_W   = 32;
    localparam int NUM_W    = VAL_W + FRAC_MAX + 1;
    localparam int DREM_W   = VAL_W + 1;
    localparam int QW       = FRAC_MAX + 1;

    // cordic start value, reciprocal of the gain of the infinite product in Q4.30
    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

    // row codes
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    // payload that rides along the chain
    typedef struct packed {
        logic [2:0][VAL_W-1:0]  mag;
        logic [2:0]             neg;
        logic [ANGLE_W-1:0]     ang;
        logic                   upper;
        logic [2:0][VAL_W-1:0]  off;
        logic                   zero;
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } t_side;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] aar_atan(input int idx);
        case (idx)
            0:  return 32'd536870912;
            1:  return 32'd316933406;
            2:  return 32'd167458907;
            3:  return 32'd85004756;
            4:  return 32'd42667331;
            5:  return 32'd21354465;
            6:  return 32'd10679838;
            7:  return 32'd5340245;
            8:  return 32'd2670163;
            9:  return 32'd1335087;
            10: return 32'd667544;
            11: return 32'd333772;
            12: return 32'd166886;
            13: return 32'd83443;
            14: return 32'd41722;
            15: return 32'd20861;
            16: return 32'd10430;
            17: return 32'd5215;
            18: return 32'd2608;
            19: return 32'd1304;
            20: return 32'd652;
            21: return 32'd326;
            22: return 32'd163;
            23: return 32'd81;
            default: return 32'd0;
        endcase
    endfunction

endpackage

// ----- src/aar_cordic_cell.sv -----
// one rotation-mode cordic iteration with its pipeline register
// depends on aar_pkg
`timescale 1ns / 1ps

module aar_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [aar_pkg::XW-1:0] i_x,
    input  logic signed [aar_pkg::XW-1:0] i_y,
    input  logic signed [aar_pkg::ZW-1:0] i_z,
    input  aar_pkg::t_side                i_side,
    output logic                          o_vld,
    output logic signed [aar_pkg::XW-1:0] o_x,
    output logic signed [aar_pkg::XW-1:0] o_y,
    output logic signed [aar_pkg::ZW-1:0] o_z,
    output aar_pkg::t_side                o_side
);
    import aar_pkg::*;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic                 r_vld;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    t_side                r_side;

    // micro-rotation, direction from the residual angle sign
    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        da = $signed({1'b0, aar_atan(STAGE)});
        if (!i_z[ZW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - da;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + da;
        end
    end

    // valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

// ----- src/aar_sqrt_cell.sv -----
// one result bit of the digit-by-digit integer square root
// depends on aar_pkg
`timescale 1ns / 1ps

module aar_sqrt_cell #(
    parameter int BIT = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [aar_pkg::RW-1:0]       i_rem,
    input  logic [aar_pkg::ROOT_W-1:0]   i_root,
    input  aar_pkg::t_side               i_side,
    output logic                         o_vld,
    output logic [aar_pkg::RW-1:0]       o_rem,
    output logic [aar_pkg::ROOT_W-1:0]   o_root,
    output aar_pkg::t_side               o_side
);
    import aar_pkg::*;

    logic [RW-1:0]     trial;
    logic [RW-1:0]     n_rem;
    logic [ROOT_W-1:0] n_root;
    logic              r_vld;
    logic [RW-1:0]     r_rem;
    logic [ROOT_W-1:0] r_root;
    t_side             r_side;

    // (root + 2^b)^2 - root^2 against the remainder
    always_comb begin
        trial  = (RW'(i_root) << (BIT + 1)) + (RW'(1) << (2 * BIT));
        n_rem  = i_rem;
        n_root = i_root;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = i_root | (ROOT_W'(1) << BIT);
        end
    end

    // valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

// ----- src/aar_div_cell.sv -----
// one quotient bit of three parallel restoring divisions by the axis length
// depends on aar_pkg
`timescale 1ns / 1ps

module aar_div_cell #(
    parameter int BIT = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic [aar_pkg::ROOT_W-1:0]          i_len,
    input  logic [2:0][aar_pkg::NUM_W-1:0]      i_num,
    input  logic [2:0][aar_pkg::DREM_W-1:0]     i_rem,
    input  logic [2:0][aar_pkg::QW-1:0]         i_q,
    input  aar_pkg::t_side                      i_side,
    output logic                                o_vld,
    output logic [aar_pkg::ROOT_W-1:0]          o_len,
    output logic [2:0][aar_pkg::NUM_W-1:0]      o_num,
    output logic [2:0][aar_pkg::DREM_W-1:0]     o_rem,
    output logic [2:0][aar_pkg::QW-1:0]         o_q,
    output aar_pkg::t_side                      o_side
);
    import aar_pkg::*;

    logic [2:0][DREM_W-1:0] shifted;
    logic [2:0][DREM_W-1:0] n_rem;
    logic [2:0][QW-1:0]     n_q;
    logic                   r_vld;
    logic [ROOT_W-1:0]      r_len;
    logic [2:0][NUM_W-1:0]  r_num;
    logic [2:0][DREM_W-1:0] r_rem;
    logic [2:0][QW-1:0]     r_q;
    t_side                  r_side;

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            shifted[k] = {i_rem[k][DREM_W-2:0], i_num[k][BIT]};
            n_rem[k]   = shifted[k];
            n_q[k]     = i_q[k];
            if (shifted[k] >= {1'b0, i_len}) begin
                n_rem[k]      = shifted[k] - {1'b0, i_len};
                n_q[k][BIT]   = 1'b1;
            end
        end
    end

    // valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len  <= i_len;
            r_num  <= i_num;
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_len  = r_len;
    assign o_num  = r_num;
    assign o_rem  = r_rem;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

// ----- src/axis_angle_rotation_matrix_top.sv -----
// Axis-angle to 4x4 rotation matrix: one input word (axis, binary angle, offset) gives four
// output words, one matrix row each, rows 0 to 3, with tlast on row 3 and the zero-axis flag
// in tuser. The datapath is a chain of cells with one register each: CORDIC_STAGES cordic
// cells, 32 square-root cells, FRAC_BITS+1 divider cells and the input, sine/cosine, sum,
// numerator, quaternion, product, matrix and serializer registers. The output port sends
// one row per cycle while tready is high, so its four rows per input word set the sustained
// rate; the chain holds only while a finished matrix waits and the serializer cannot take it.
// depends on aar_pkg, aar_cordic_cell, aar_sqrt_cell, aar_div_cell and the macros header
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_top_macros.svh"

module axis_angle_rotation_matrix_top #(
    parameter int FRAC_BITS     = 16,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // axis_x, axis_y, axis_z, angle, offset_x, offset_y, offset_z
    input  logic [aar_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // elem0, elem1, elem2, elem3
    output logic [aar_pkg::OUT_W-1:0]   o_m_axis_tdata,
    // row_index, zero_axis
    output logic [aar_pkg::USER_W-1:0]  o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);
    import aar_pkg::*;

    localparam int NDIV = FRAC_BITS + 1;

    // flow control
    logic en;
    logic out_take;
    logic ser_load;

    // input stage
    logic                         r0_vld;
    t_side                        r0_side;
    logic signed [VAL_W-1:0]      in_val [3];
    t_side                        n0_side;

    // cordic chain
    logic [CORDIC_STAGES:0]       cv;
    logic signed [XW-1:0]         cx [CORDIC_STAGES+1];
    logic signed [XW-1:0]         cy [CORDIC_STAGES+1];
    logic signed [ZW-1:0]         cz [CORDIC_STAGES+1];
    t_side                        cside [CORDIC_STAGES+1];
    logic [ANG_EXT-1:0]           ang_ext;
    logic [31:0]                  z_start;
    t_side                        n_c0_side;

    // sine / cosine and squares
    logic signed [XW-1:0]         c_rnd;
    logic signed [XW-1:0]         s_rnd;
    t_side                        n_cs_side;
    logic                         r_cs_vld;
    t_side                        r_cs_side;
    logic [2:0][63:0]             r_sq;

    // length squared
    logic                         r_sum_vld;
    t_side                        n_sum_side;
    t_side                        r_sum_side;
    logic [63:0]                  r_sum;

    // square-root chain
    logic [ROOT_W:0]              sv;
    logic [RW-1:0]                srem [ROOT_W+1];
    logic [ROOT_W-1:0]            sroot [ROOT_W+1];
    t_side                        sside [ROOT_W+1];

    // numerators
    logic [2:0][NUM_W-1:0]        n_num;
    logic                         r_num_vld;
    logic [ROOT_W-1:0]            r_len;
    logic [2:0][NUM_W-1:0]        r_num;
    logic [2:0][DREM_W-1:0]       r_drem;
    t_side                        r_num_side;

    // divider chain
    logic [NDIV:0]                dv;
    logic [ROOT_W-1:0]            dlen [NDIV+1];
    logic [2:0][NUM_W-1:0]        dnum [NDIV+1];
    logic [2:0][DREM_W-1:0]       drem [NDIV+1];
    logic [2:0][QW-1:0]           dq [NDIV+1];
    t_side                        dside [NDIV+1];

    // quaternion
    logic signed [CS_W-1:0]       u [3];
    logic signed [PROD_W-1:0]     us [3];
    logic signed [PROD_W-1:0]     rnd_q [3];
    logic                         r_q_vld;
    t_side                        r_q_side;
    logic signed [CS_W-1:0]       r_qv [3];

    // quaternion products: xx yy zz xy xz yz wx wy wz
    logic                         r_p_vld;
    t_side                        r_p_side;
    logic signed [PROD_W-1:0]     r_p [9];

    // matrix elements
    logic signed [63:0]           pe [9];
    logic signed [63:0]           one2;
    logic [VAL_W-1:0]             n_m [9];
    logic                         r_mv;
    logic [VAL_W-1:0]             r_m [9];
    logic [2:0][VAL_W-1:0]        r_m_off;
    logic                         r_m_zero;

    // row serializer
    logic                         r_sv;
    logic [1:0]                   r_row;
    logic [VAL_W-1:0]             r_sm [9];
    logic [2:0][VAL_W-1:0]        r_soff;
    logic                         r_szero;

    // round half up at the fraction point, then saturate to 32 bits
    function automatic logic [VAL_W-1:0] rnd_sat(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (t > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (t < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return t[VAL_W-1:0];
    endfunction

    // the whole chain moves unless a finished matrix cannot leave
    assign out_take        = r_sv & i_m_axis_tready;
    assign ser_load        = !r_sv || (out_take && (r_row == ROW_LAST));
    assign en              = !r_mv || ser_load;
    assign o_s_axis_tready = en;

    // unpack and take magnitudes
    always_comb begin
        in_val[0] = $signed(i_s_axis_tdata[31:0]);
        in_val[1] = $signed(i_s_axis_tdata[63:32]);
        in_val[2] = $signed(i_s_axis_tdata[95:64]);
        n0_side   = '0;
        for (int k = 0; k < 3; k++) begin
            n0_side.neg[k] = in_val[k][VAL_W-1];
            n0_side.mag[k] = in_val[k][VAL_W-1] ? VAL_W'(-in_val[k]) : in_val[k];
        end
        n0_side.ang    = i_s_axis_tdata[111:96];
        n0_side.off[0] = i_s_axis_tdata[143:112];
        n0_side.off[1] = i_s_axis_tdata[175:144];
        n0_side.off[2] = i_s_axis_tdata[207:176];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_side <= n0_side;
        end
    end

    // half angle on a 2^32-per-turn scale, upper half folded by a quarter turn
    always_comb begin
        ang_ext         = ANG_EXT'(r0_side.ang);
        z_start         = {1'b0, ang_ext[ANGLE_BITS-1:0], {(31 - ANGLE_BITS){1'b0}}};
        n_c0_side       = r0_side;
        n_c0_side.upper = z_start[30];
    end

    assign cv[0]    = r0_vld;
    assign cx[0]    = GAIN_Q30;
    assign cy[0]    = '0;
    assign cz[0]    = $signed({3'b000, z_start[29:0]});
    assign cside[0] = n_c0_side;

    // cordic cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        aar_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (cv[g]),
            .i_x     (cx[g]),
            .i_y     (cy[g]),
            .i_z     (cz[g]),
            .i_side  (cside[g]),
            .o_vld   (cv[g+1]),
            .o_x     (cx[g+1]),
            .o_y     (cy[g+1]),
            .o_z     (cz[g+1]),
            .o_side  (cside[g+1])
        );
    end

    // round cordic outputs, undo the fold
    always_comb begin
        c_rnd     = (cx[CORDIC_STAGES] + (XW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        s_rnd     = (cy[CORDIC_STAGES] + (XW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        n_cs_side = cside[CORDIC_STAGES];
        if (cside[CORDIC_STAGES].upper) begin
            n_cs_side.c = -s_rnd[CS_W-1:0];
            n_cs_side.s = c_rnd[CS_W-1:0];
        end else begin
            n_cs_side.c = c_rnd[CS_W-1:0];
            n_cs_side.s = s_rnd[CS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
        end else if (en) begin
            r_cs_vld  <= cv[CORDIC_STAGES];
            r_sum_vld <= r_cs_vld;
        end
    end

    // zero-axis flag from the squares
    always_comb begin
        n_sum_side      = r_cs_side;
        n_sum_side.zero = (r_sq[0] | r_sq[1] | r_sq[2]) == 64'd0;
    end

    // squares of the axis parts, then their sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cs_side <= n_cs_side;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 64'(cside[CORDIC_STAGES].mag[k]) * 64'(cside[CORDIC_STAGES].mag[k]);
            end
            r_sum      <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sum_side <= n_sum_side;
        end
    end

    // square-root cells, most significant bit first
    assign sv[0]    = r_sum_vld;
    assign srem[0]  = RW'(r_sum);
    assign sroot[0] = '0;
    assign sside[0] = r_sum_side;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        aar_sqrt_cell #(
            .BIT (ROOT_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sv[g]),
            .i_rem   (srem[g]),
            .i_root  (sroot[g]),
            .i_side  (sside[g]),
            .o_vld   (sv[g+1]),
            .o_rem   (srem[g+1]),
            .o_root  (sroot[g+1]),
            .o_side  (sside[g+1])
        );
    end

    // numerators |a|*2^F + L/2
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num[k] = (NUM_W'(sside[ROOT_W].mag[k]) << FRAC_BITS)
                     + NUM_W'(sroot[ROOT_W] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vld <= 1'b0;
        end else if (en) begin
            r_num_vld <= sv[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_len      <= sroot[ROOT_W];
            r_num      <= n_num;
            r_num_side <= sside[ROOT_W];
            for (int k = 0; k < 3; k++) begin
                r_drem[k] <= DREM_W'(n_num[k] >> (FRAC_BITS + 1));
            end
        end
    end

    // divider cells, quotient bit F down to 0
    assign dv[0]    = r_num_vld;
    assign dlen[0]  = r_len;
    assign dnum[0]  = r_num;
    assign drem[0]  = r_drem;
    assign dq[0]    = '0;
    assign dside[0] = r_num_side;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        aar_div_cell #(
            .BIT (FRAC_BITS - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv[g]),
            .i_len   (dlen[g]),
            .i_num   (dnum[g]),
            .i_rem   (drem[g]),
            .i_q     (dq[g]),
            .i_side  (dside[g]),
            .o_vld   (dv[g+1]),
            .o_len   (dlen[g+1]),
            .o_num   (dnum[g+1]),
            .o_rem   (drem[g+1]),
            .o_q     (dq[g+1]),
            .o_side  (dside[g+1])
        );
    end

    // signed unit axis times half-angle sine, rounded
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u[k]     = dside[NDIV].neg[k] ? -$signed({2'b00, dq[NDIV][k]})
                                          : $signed({2'b00, dq[NDIV][k]});
            us[k]    = u[k] * dside[NDIV].s;
            rnd_q[k] = (us[k] + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_mv    <= 1'b0;
        end else if (en) begin
            r_q_vld <= dv[NDIV];
            r_p_vld <= r_q_vld;
            r_mv    <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_side <= dside[NDIV];
            for (int k = 0; k < 3; k++) begin
                r_qv[k] <= rnd_q[k][CS_W-1:0];
            end
        end
    end

    // quaternion products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_side <= r_q_side;
            r_p[0]   <= r_qv[0] * r_qv[0];
            r_p[1]   <= r_qv[1] * r_qv[1];
            r_p[2]   <= r_qv[2] * r_qv[2];
            r_p[3]   <= r_qv[0] * r_qv[1];
            r_p[4]   <= r_qv[0] * r_qv[2];
            r_p[5]   <= r_qv[1] * r_qv[2];
            r_p[6]   <= r_q_side.c * r_qv[0];
            r_p[7]   <= r_q_side.c * r_qv[1];
            r_p[8]   <= r_q_side.c * r_qv[2];
        end
    end

    // matrix elements, identity on a zero axis
    always_comb begin
        one2 = 64'sd1 <<< (2 * FRAC_BITS);
        for (int k = 0; k < 9; k++) begin
            pe[k] = 64'(r_p[k]);
        end
        n_m[0] = rnd_sat(one2 - 2 * (pe[1] + pe[2]));
        n_m[1] = rnd_sat(2 * (pe[3] + pe[8]));
        n_m[2] = rnd_sat(2 * (pe[4] - pe[7]));
        n_m[3] = rnd_sat(2 * (pe[3] - pe[8]));
        n_m[4] = rnd_sat(one2 - 2 * (pe[0] + pe[2]));
        n_m[5] = rnd_sat(2 * (pe[5] + pe[6]));
        n_m[6] = rnd_sat(2 * (pe[4] + pe[7]));
        n_m[7] = rnd_sat(2 * (pe[5] - pe[6]));
        n_m[8] = rnd_sat(one2 - 2 * (pe[0] + pe[1]));
        if (r_p_side.zero) begin
            for (int k = 0; k < 9; k++) begin
                n_m[k] = '0;
            end
            n_m[0] = VAL_W'(1) << FRAC_BITS;
            n_m[4] = VAL_W'(1) << FRAC_BITS;
            n_m[8] = VAL_W'(1) << FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m      <= n_m;
            r_m_off  <= r_p_side.off;
            r_m_zero <= r_p_side.zero;
        end
    end

    // row serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_row <= ROW_FIRST;
        end else if (ser_load) begin
            r_sv  <= r_mv;
            r_row <= ROW_FIRST;
        end else if (out_take) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load && r_mv) begin
            r_sm    <= r_m;
            r_soff  <= r_m_off;
            r_szero <= r_m_zero;
        end
    end

    // row select
    always_comb begin
        case (r_row)
            2'd0: o_m_axis_tdata = {32'd0, r_sm[2], r_sm[1], r_sm[0]};
            2'd1: o_m_axis_tdata = {32'd0, r_sm[5], r_sm[4], r_sm[3]};
            2'd2: o_m_axis_tdata = {32'd0, r_sm[8], r_sm[7], r_sm[6]};
            default: o_m_axis_tdata = {VAL_W'(1) << FRAC_BITS, r_soff[2], r_soff[1], r_soff[0]};
        endcase
    end

    assign o_m_axis_tvalid = r_sv;
    assign o_m_axis_tuser  = {r_szero, r_row};
    assign o_m_axis_tlast  = r_row == ROW_LAST;

    // checks
    `AAR_ASSERT_NEXT(a_row_step, i_clk, i_rst_n, out_take && (r_row != ROW_LAST), o_m_axis_tvalid && (o_m_axis_tuser[1:0] == $past(o_m_axis_tuser[1:0]) + 2'd1), "row sequence broken")
    `AAR_ASSERT_NEXT(a_load_row0, i_clk, i_rst_n, r_mv && ser_load, r_sv && (r_row == ROW_FIRST), "matrix not loaded at row 0")
    `AAR_ASSERT_NEXT(a_zero_held, i_clk, i_rst_n, out_take && !o_m_axis_tlast, o_m_axis_tuser[2] == $past(o_m_axis_tuser[2]), "zero flag changed inside a matrix")
    `AAR_ASSERT_NOW(a_no_block, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "chain stalled with idle output")

endmodule
